FILE: hw/rtl/ues_pkg.sv
// Package for the ungapped extension scorer: constants, codes and shared types.
`default_nettype none

package ues_pkg;

    // Alphabet and neighbourhood limits
    localparam int ALPHABET          = 32;
    localparam int MAX_NEIGHBOURHOOD = 64;

    // Field widths
    localparam int LETTER_W = 5;
    localparam int SCORE_W  = 8;
    localparam int BIAS_W   = 7;
    localparam int THR_W    = 7;
    localparam int LEFT_W   = 6;
    localparam int TOTAL_W  = 7;
    localparam int ADDR_W   = 2 * LETTER_W;
    localparam int DEPTH    = ALPHABET * ALPHABET;
    localparam int POS_W    = $clog2(MAX_NEIGHBOURHOOD + 1);

    // Stream packing
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // Item kinds carried on the input tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_OFFSET     = 2'd0,
        REG_SCORE_THRESHOLD = 2'd1,
        REG_LEFT_LENGTH     = 2'd2,
        REG_TOTAL_LENGTH    = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [BIAS_W-1:0]  BIAS_RESET  = 7'd4;
    localparam logic [THR_W-1:0]   THR_RESET   = 7'd20;
    localparam logic [LEFT_W-1:0]  LEFT_RESET  = 6'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 7'd28;

    // Configuration as seen by the scoring core
    typedef struct packed {
        logic [BIAS_W-1:0]  bias_offset;
        logic [THR_W-1:0]   score_threshold;
        logic [LEFT_W-1:0]  left_length;
        logic [TOTAL_W-1:0] total_length;
    } cfg_t;

    // Outcome of one scored position
    typedef struct packed {
        logic             last;
        logic             passed;
        logic [THR_W-1:0] best_clipped;
    } result_t;

endpackage : ues_pkg

`default_nettype wire

FILE: hw/rtl/ues_score_core.sv
// Running/best score recurrence for one neighbourhood pair, one position per step.
`default_nettype none

module ues_score_core
    import ues_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,       // apply one scored position
    input  wire logic [SCORE_W-1:0] table_raw,  // raw table entry, two's complement
    input  wire cfg_t               cfg,
    output result_t                 res
);

    logic [SCORE_W-1:0] running_reg, running_next;
    logic [SCORE_W-1:0] best_reg, best_next;
    logic [POS_W-1:0]   position_reg, position_next;

    logic [SCORE_W-1:0] entry;
    logic [SCORE_W:0]   sum;
    logic [SCORE_W-1:0] sat;
    logic [SCORE_W-1:0] bias_ext;
    logic [SCORE_W-1:0] floored;
    logic [SCORE_W-1:0] best_upd;
    logic [SCORE_W-1:0] thr_ext;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   eff_total;
    logic               left_hit;

    // Bias, saturating add, floored subtract, keep best
    always_comb
    begin
        bias_ext = {1'b0, cfg.bias_offset};
        thr_ext  = {1'b0, cfg.score_threshold};
        entry    = table_raw + bias_ext;
        sum      = {1'b0, running_reg} + {1'b0, entry};
        sat      = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
        floored  = (sat > bias_ext) ? (sat - bias_ext) : '0;
        best_upd = (floored > best_reg) ? floored : best_reg;
        pos_inc  = position_reg + POS_W'(1);
        left_hit = (cfg.left_length != '0) && (pos_inc == POS_W'(cfg.left_length));
    end

    // Neighbourhood length: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (cfg.total_length == '0)
            eff_total = POS_W'(1);
        else if (POS_W'(cfg.total_length) > POS_W'(MAX_NEIGHBOURHOOD))
            eff_total = POS_W'(MAX_NEIGHBOURHOOD);
        else
            eff_total = POS_W'(cfg.total_length);
    end

    // Result of this position
    always_comb
    begin
        res.last         = (pos_inc >= eff_total);
        res.passed       = (best_upd >= thr_ext);
        res.best_clipped = (best_upd < thr_ext) ? best_upd[THR_W-1:0] : cfg.score_threshold;
    end

    // Next state
    always_comb
    begin
        running_next  = running_reg;
        best_next     = best_reg;
        position_next = position_reg;
        if (step)
        begin
            if (res.last)
            begin
                running_next  = '0;
                best_next     = '0;
                position_next = '0;
            end
            else
            begin
                running_next  = left_hit ? best_upd : floored;
                best_next     = best_upd;
                position_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= '0;
            best_reg     <= '0;
            position_reg <= '0;
        end
        else
        begin
            running_reg  <= running_next;
            best_reg     <= best_next;
            position_reg <= position_next;
        end
    end

    // Running score never exceeds the best of the pair
    a_run_le_best: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg <= best_reg)
        else $error("running score above best score");

    // Position stays below the neighbourhood maximum
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg < POS_W'(MAX_NEIGHBOURHOOD))
        else $error("position out of range");

    // A finished pair leaves cleared state behind
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.last) |=> (position_reg == '0 && best_reg == '0 && running_reg == '0))
        else $error("state not cleared after last position");

endmodule : ues_score_core

`default_nettype wire

FILE: hw/rtl/ungapped_extension_scorer_top.sv
// Top level of the ungapped extension scorer: stream ports, table memory, result register.
`default_nettype none

// The block takes one item per clock while ready is high: a load writes one
// substitution table entry, a score item reads the entry for its letter pair
// from the 1024x8 table memory into a read register, and the scoring stage
// updates the running and best scores from it. A result is registered when
// the last position of a pair is applied; m_axis_tvalid is driven from that
// register. Input ready drops only while a finished result sits in the output
// register, the downstream side does not take it and the scoring stage holds
// the last position of the next pair. The table holds no reset value: every
// entry used for scoring must have been loaded first. Configuration is to be
// written by the user through the cfg port only while no transaction is in
// flight (not enforced); a pair already under way keeps its position.

module ungapped_extension_scorer_top
    import ues_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [4:0] subject_letter, [9:5] query_letter,
                                                       // [17:10] table_score, [23:18] zero
    input  wire logic                   s_axis_tuser,  // [0] opcode
    // Result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [0] passed, [7:1] best_clipped
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SCORE_W-1:0] table_mem [DEPTH];
    logic [SCORE_W-1:0] rd_data_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    cfg_t               cfg_reg;
    result_t            res;

    logic               in_accept;
    logic               s1_fire;
    logic [ADDR_W-1:0]  addr;
    logic [SCORE_W-1:0] load_score;

    // Input decode
    assign addr       = {s_axis_tdata[LETTER_W-1:0], s_axis_tdata[2*LETTER_W-1:LETTER_W]};
    assign load_score = s_axis_tdata[2*LETTER_W+SCORE_W-1:2*LETTER_W];
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    // Scoring stage advances unless its result would overwrite a waiting one
    assign s1_fire       = s1_valid_reg && (!res.last || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    // Table memory: one write or one registered read per transaction
    always_ff @(posedge clk)
    begin
        if (in_accept && s_axis_tuser == OP_LOAD)
            table_mem[addr] <= load_score;
        if (in_accept && s_axis_tuser == OP_SCORE)
            rd_data_reg <= table_mem[addr];
    end

    ues_score_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .table_raw (rd_data_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // Pipeline and output control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept && s_axis_tuser == OP_SCORE)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire && res.last)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && res.last)
            out_data_reg <= {res.best_clipped, res.passed};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bias_offset     <= BIAS_RESET;
            cfg_reg.score_threshold <= THR_RESET;
            cfg_reg.left_length     <= LEFT_RESET;
            cfg_reg.total_length    <= TOTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_BIAS_OFFSET:     cfg_reg.bias_offset     <= cfg_data[BIAS_W-1:0];
                REG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data[THR_W-1:0];
                REG_LEFT_LENGTH:     cfg_reg.left_length     <= cfg_data[LEFT_W-1:0];
                REG_TOTAL_LENGTH:    cfg_reg.total_length    <= cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // A held result is never overwritten by the scoring stage
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && s1_valid_reg && res.last) |-> !s1_fire)
        else $error("result register overwritten");

    // A score transaction always reaches the scoring stage next cycle
    a_score_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tuser == OP_SCORE) |=> s1_valid_reg)
        else $error("score transaction lost");

    // A new result appears only after the scoring stage finished a pair
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_fire && res.last))
        else $error("result without finished pair");

endmodule : ungapped_extension_scorer_top

`default_nettype wire

FILE: tb/sv/ungapped_extension_scorer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the ungapped extension scorer top level.
module ungapped_extension_scorer_top_tb
    import ues_pkg::*;
;

    localparam int CLK_PERIOD    = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 500;
    localparam int MIN_RESULTS   = 50;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;

    // One input transaction, as the block sees it
    typedef struct packed {
        logic                opcode;
        logic [LETTER_W-1:0] subject_letter;
        logic [LETTER_W-1:0] query_letter;
        logic [SCORE_W-1:0]  table_score;
    } residue_item_t;

    // One result transaction
    typedef struct packed {
        logic             passed;
        logic [THR_W-1:0] best_clipped;
    } pair_score_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = OP_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index     = REG_BIAS_OFFSET;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    ungapped_extension_scorer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: substitution matrix, scores and a copy of the registers
    logic [SCORE_W-1:0] subst_matrix [DEPTH];
    logic [SCORE_W-1:0] run_acc   = '0;
    logic [SCORE_W-1:0] peak_acc  = '0;
    int unsigned        pair_pos  = 0;
    logic [BIAS_W-1:0]  cur_bias  = BIAS_RESET;
    logic [THR_W-1:0]   cur_thr   = THR_RESET;
    logic [LEFT_W-1:0]  cur_left  = LEFT_RESET;
    logic [TOTAL_W-1:0] cur_total = TOTAL_RESET;

    residue_item_t feed_q [$];
    pair_score_t   expected_scores [$];
    int unsigned   items_queued   = 0;
    int unsigned   items_taken    = 0;
    int unsigned   random_items   = 0;
    int unsigned   results_due    = 0;
    int unsigned   results_seen   = 0;
    int unsigned   error_count    = 0;
    bit            hold_request   = 1'b0;

    // Stimulus bookkeeping: only loaded entries are ever scored
    bit                entry_loaded [DEPTH];
    logic [ADDR_W-1:0] loaded_addrs [$];

    // Positions per pair after clamping the total length
    function automatic int unsigned pair_span();
        if (cur_total == 0)
            return 1;
        if (cur_total > MAX_NEIGHBOURHOOD)
            return MAX_NEIGHBOURHOOD;
        return cur_total;
    endfunction

    // Applies one accepted input transaction and queues any result it causes
    function automatic void extend_pair(input residue_item_t it);
        logic [ADDR_W-1:0]  addr;
        logic [SCORE_W-1:0] biased;
        logic [SCORE_W:0]   acc;
        logic [SCORE_W-1:0] clipped;
        pair_score_t        res;
        addr = {it.subject_letter, it.query_letter};
        if (it.opcode == OP_LOAD)
        begin
            subst_matrix[addr] = it.table_score;
            return;
        end
        // biased entry wraps at 8 bits, sum saturates, bias removed with floor
        biased = subst_matrix[addr] + SCORE_W'(cur_bias);
        acc = {1'b0, run_acc} + {1'b0, biased};
        if (acc > 9'd255)
            acc = 9'd255;
        run_acc = (acc > cur_bias) ? SCORE_W'(acc - cur_bias) : '0;
        if (run_acc > peak_acc)
            peak_acc = run_acc;
        pair_pos++;
        if (cur_left != 0 && pair_pos == cur_left)
            run_acc = peak_acc;
        if (pair_pos >= pair_span())
        begin
            clipped = (peak_acc < cur_thr) ? peak_acc : SCORE_W'(cur_thr);
            res.passed       = (clipped >= cur_thr);
            res.best_clipped = clipped[THR_W-1:0];
            expected_scores.push_back(res);
            results_due++;
            run_acc  = '0;
            peak_acc = '0;
            pair_pos = 0;
        end
    endfunction

    // Mostly small substitution scores, with the signed extremes now and then
    function automatic logic [SCORE_W-1:0] pick_table_score();
        case ($urandom_range(0, 7))
            0:       return 8'h7F;
            1:       return 8'h80;
            2:       return SCORE_W'($urandom_range(0, 255));
            default: return SCORE_W'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    function automatic void queue_load(input logic [LETTER_W-1:0] subj,
                                       input logic [LETTER_W-1:0] qry,
                                       input logic [SCORE_W-1:0]  value);
        residue_item_t it;
        it.opcode         = OP_LOAD;
        it.subject_letter = subj;
        it.query_letter   = qry;
        it.table_score    = value;
        if (!entry_loaded[{subj, qry}])
        begin
            entry_loaded[{subj, qry}] = 1'b1;
            loaded_addrs.push_back({subj, qry});
        end
        feed_q.push_back(it);
        items_queued++;
    endfunction

    function automatic void queue_score(input logic [ADDR_W-1:0] addr);
        residue_item_t it;
        it.opcode         = OP_SCORE;
        it.subject_letter = addr[ADDR_W-1:LETTER_W];
        it.query_letter   = addr[LETTER_W-1:0];
        it.table_score    = SCORE_W'($urandom_range(0, 255));
        feed_q.push_back(it);
        items_queued++;
    endfunction

    function automatic int unsigned queue_random_load();
        queue_load(LETTER_W'($urandom_range(0, ALPHABET - 1)),
                   LETTER_W'($urandom_range(0, ALPHABET - 1)), pick_table_score());
        return 1;
    endfunction

    function automatic int unsigned queue_random_score();
        queue_score(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
        return 1;
    endfunction

    // Whole pairs with loads sprinkled in, some noise and some cut-short pairs
    function automatic void queue_phase(input int unsigned target);
        int unsigned n;
        int unsigned span;
        int unsigned cut;
        n = 0;
        span = pair_span();
        while (n < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    n += queue_random_load();
            end
            else
            begin
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
                repeat (cut)
                begin
                    if ($urandom_range(0, 7) == 0)
                        n += queue_random_load();
                    n += queue_random_score();
                end
            end
        end
        random_items += n;
    endfunction

    // Register write on the configuration channel; predictor copy follows it
    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BIAS_OFFSET:     cur_bias  = BIAS_W'(value);
            REG_SCORE_THRESHOLD: cur_thr   = THR_W'(value);
            REG_LEFT_LENGTH:     cur_left  = LEFT_W'(value);
            REG_TOTAL_LENGTH:    cur_total = TOTAL_W'(value);
        endcase
    endtask

    task automatic configure(input int unsigned bias, input int unsigned thr,
                             input int unsigned left, input int unsigned total);
        write_reg(REG_BIAS_OFFSET, bias);
        write_reg(REG_SCORE_THRESHOLD, thr);
        write_reg(REG_LEFT_LENGTH, left);
        write_reg(REG_TOTAL_LENGTH, total);
    endtask

    // Wait until every queued transaction is taken and every result is back
    task automatic settle();
        do
            @(posedge clk);
        while (items_taken != items_queued || expected_scores.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    residue_item_t on_bus;
    int unsigned   burst_left = 0;
    int unsigned   gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                extend_pair(on_bus);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (feed_q.size() != 0)
                begin
                    on_bus = feed_q.pop_front();
                    s_axis_tdata  <= {{(IN_TDATA_W - ADDR_W - SCORE_W){1'b0}},
                                      on_bus.table_score, on_bus.query_letter,
                                      on_bus.subject_letter};
                    s_axis_tuser  <= on_bus.opcode;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction, stalls in modes of random length
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    pair_score_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_scores.size() == 0)
                begin
                    $error("result with nothing expected: tdata 0x%h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (m_axis_tdata[0] !== want.passed)
                    begin
                        $error("passed: expected %0d, got %0d", want.passed, m_axis_tdata[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[7:1] !== want.best_clipped)
                    begin
                        $error("best_clipped: expected %0d, got %0d",
                               want.best_clipped, m_axis_tdata[7:1]);
                        error_count++;
                    end
                end
            end
            // long back-pressure on request so the block fills and stalls its input
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 80);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run limit
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int unsigned phase_no;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Signed extremes and alternating bit patterns into the matrix
        queue_load(5'd0, 5'd0, 8'h7F);
        queue_load(5'd31, 5'd31, 8'h80);
        queue_load(5'd0, 5'd31, 8'h00);
        queue_load(5'd31, 5'd0, 8'hFF);
        queue_load(5'd21, 5'd10, 8'h55);
        queue_load(5'd10, 5'd21, 8'hAA);
        // One full pair on the reset register values
        repeat (pair_span())
            void'(queue_random_score());
        settle();

        // Saturation at 255 and the replacement early in a short pair
        configure(127, 127, 2, 4);
        queue_score({5'd0, 5'd0});
        queue_score({5'd31, 5'd31});
        queue_score({5'd0, 5'd31});
        queue_score({5'd31, 5'd0});
        settle();

        // Zero threshold, zero left length, zero total acting as one
        configure(0, 0, 0, 0);
        queue_score({5'd0, 5'd31});
        queue_score({5'd31, 5'd0});
        queue_score({5'd21, 5'd10});
        queue_score({5'd10, 5'd21});
        settle();

        // Random phases, the first few on extreme settings; a phase may end
        // mid-pair so the next settings apply to a pair already under way
        phase_no = 0;
        while (random_items < RANDOM_ITEMS || results_due < MIN_RESULTS)
        begin
            case (phase_no)
                0:       configure(127, 127, 63, 127);
                1:       configure(4, 20, 1, 2);
                2:       configure(127, 1, 0, 64);
                3:       configure(0, 127, 5, 3);
                4:       configure(0, 0, 63, 1);
                default:
                    configure(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 10),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 30),
                              $urandom_range(0, 14),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(2, 12));
            endcase
            if (phase_no == 1 || phase_no == 6)
                hold_request = 1'b1;
            queue_phase($urandom_range(40, 80));
            settle();
            phase_no++;
        end

        if (error_count == 0 && expected_scores.size() == 0 && results_seen == results_due)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
